// ===== hdl/cpm_pkg.sv =====
`timescale 1ns / 1ps

package cpm_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int MIN_VERTICES = 3;

    localparam int COORD_W    = 16;
    localparam int MUL_W      = COORD_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int CNT_W      = $clog2(MAX_VERTICES + 2);
    localparam int AREA_W     = PROD_W + $clog2(MAX_VERTICES);
    localparam int SUM_W      = COORD_W + 1 + $clog2(MAX_VERTICES);
    localparam int FRAC_W     = 8;
    localparam int DIV_W      = SUM_W + FRAC_W;
    localparam int DCNT_W     = $clog2(DIV_W);

    localparam int AREA_OUT_W = 34;
    localparam int SIZE_W     = 16;
    localparam int CTR_W      = 17;
    localparam int CENT_W     = 24;

    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] OVER_CNT = CNT_W'(MAX_VERTICES + 1);
    localparam logic [CNT_W-1:0] MIN_CNT  = CNT_W'(MIN_VERTICES);
    localparam logic [AREA_OUT_W-1:0] AREA_SAT = '1;

endpackage

// ===== hdl/convex_polygon_measure_top.sv =====
`timescale 1ns / 1ps

// The first vertex passes through S_IDLE and S_VTX, the second also through S_E1, and each later one
// through S_E1, S_T0 and S_T1; one shared 17x17 multiplier forms the four products of each later
// vertex, one per cycle. After the marked vertex is worked, the result follows from four products for
// the wrap-around turns, two for the closing edge, then a bit-serial divider for each centroid.
// A finished result waits in the output register while the next polygon streams in.
// Synchronous active-low reset clears the sequencer, the output valid and all polygon sums.
module convex_polygon_measure_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vertex_valid,
    output logic                                 o_vertex_ready,
    input  logic signed [cpm_pkg::COORD_W-1:0]   i_vertex_x,
    input  logic signed [cpm_pkg::COORD_W-1:0]   i_vertex_y,
    input  logic                                 i_last_vertex,
    output logic                                 o_result_valid,
    input  logic                                 i_result_ready,
    output logic        [cpm_pkg::AREA_OUT_W-1:0] o_doubled_area,
    output logic        [cpm_pkg::SIZE_W-1:0]    o_frame_width,
    output logic        [cpm_pkg::SIZE_W-1:0]    o_frame_height,
    output logic signed [cpm_pkg::CTR_W-1:0]     o_frame_center_x_doubled,
    output logic signed [cpm_pkg::CTR_W-1:0]     o_frame_center_y_doubled,
    output logic signed [cpm_pkg::CENT_W-1:0]    o_centroid_x_q8,
    output logic signed [cpm_pkg::CENT_W-1:0]    o_centroid_y_q8,
    output logic                                 o_is_convex,
    output logic                                 o_too_few_points,
    output logic                                 o_too_many_points
);
    import cpm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_VTX, S_E1, S_T0, S_T1, S_CHK, S_EF0, S_EF1,
        S_DLOAD, S_DIV, S_DSTORE, S_PUT
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE, ACT_AREA_ADD, ACT_AREA_SUB, ACT_TURN_LOAD, ACT_TURN_FIRST, ACT_TURN_CHECK
    } t_act;

    typedef enum logic [1:0] {
        TS_VTX, TS_WRAP1, TS_WRAP2
    } t_tsel;

    t_state r_state, n_state;
    t_act   r_act, n_act;
    t_tsel  r_tsel, n_tsel;

    logic signed [COORD_W-1:0] r_vx, n_vx, r_vy, n_vy;
    logic                      r_last, n_last;
    logic signed [COORD_W-1:0] r_fx, n_fx, r_fy, n_fy, r_sx, n_sx, r_sy, n_sy;
    logic signed [COORD_W-1:0] r_ox, n_ox, r_oy, n_oy, r_nx, n_nx, r_ny, n_ny;
    logic signed [COORD_W-1:0] r_minx, n_minx, r_maxx, n_maxx, r_miny, n_miny, r_maxy, n_maxy;
    logic signed [AREA_W-1:0]  r_area, n_area;
    logic signed [SUM_W-1:0]   r_sumx, n_sumx, r_sumy, n_sumy;
    logic        [CNT_W-1:0]   r_count, n_count;
    logic                      r_fsign, n_fsign, r_agree, n_agree;
    logic signed [PROD_W-1:0]  r_prod, n_prod, r_turn, n_turn;
    logic                      r_few, n_few, r_many, n_many;
    logic                      r_dsel, n_dsel, r_dneg, n_dneg;
    logic        [DIV_W-1:0]   r_quo, n_quo;
    logic        [CNT_W-1:0]   r_rem, n_rem;
    logic        [DCNT_W-1:0]  r_dcnt, n_dcnt;
    logic signed [CENT_W-1:0]  r_cx, n_cx, r_cy, n_cy;

    logic                          r_o_valid, n_o_valid;
    logic        [AREA_OUT_W-1:0]  r_o_area, n_o_area;
    logic        [SIZE_W-1:0]      r_o_w, n_o_w, r_o_h, n_o_h;
    logic signed [CTR_W-1:0]       r_o_cx2, n_o_cx2, r_o_cy2, n_o_cy2;
    logic signed [CENT_W-1:0]      r_o_mx, n_o_mx, r_o_my, n_o_my;
    logic                          r_o_conv, n_o_conv, r_o_few, n_o_few, r_o_many, n_o_many;

    logic signed [MUL_W-1:0]   m_a, m_b;
    logic signed [COORD_W-1:0] t_ax, t_ay, t_bx, t_by, t_cx, t_cy;
    logic signed [MUL_W-1:0]   abx, aby, bcx, bcy;
    logic signed [PROD_W:0]    turn_diff;
    logic                      turn_neg;
    logic        [CNT_W:0]     div_trial;
    logic        [SUM_W-1:0]   sum_mag;
    logic signed [SUM_W-1:0]   sum_sel;
    logic        [DIV_W-1:0]   quo_signed;
    logic        [AREA_W-1:0]  area_mag;
    logic signed [MUL_W-1:0]   box_w, box_h, box_cx, box_cy;
    logic                      accept_in, take_out;

    assign accept_in = i_vertex_valid && (r_state == S_IDLE);
    assign take_out  = r_o_valid && i_result_ready;

    always_comb begin
        unique case (r_tsel)
            TS_WRAP1: begin
                t_ax = r_ox; t_ay = r_oy; t_bx = r_nx; t_by = r_ny; t_cx = r_fx; t_cy = r_fy;
            end
            TS_WRAP2: begin
                t_ax = r_nx; t_ay = r_ny; t_bx = r_fx; t_by = r_fy; t_cx = r_sx; t_cy = r_sy;
            end
            default: begin
                t_ax = r_ox; t_ay = r_oy; t_bx = r_nx; t_by = r_ny; t_cx = r_vx; t_cy = r_vy;
            end
        endcase
        abx = {t_bx[COORD_W-1], t_bx} - {t_ax[COORD_W-1], t_ax};
        aby = {t_by[COORD_W-1], t_by} - {t_ay[COORD_W-1], t_ay};
        bcx = {t_cx[COORD_W-1], t_cx} - {t_bx[COORD_W-1], t_bx};
        bcy = {t_cy[COORD_W-1], t_cy} - {t_by[COORD_W-1], t_by};
    end

    assign turn_diff = {r_turn[PROD_W-1], r_turn} - {r_prod[PROD_W-1], r_prod};
    assign turn_neg  = turn_diff[PROD_W];

    assign div_trial  = {r_rem, r_quo[DIV_W-1]};
    assign sum_sel    = r_dsel ? r_sumy : r_sumx;
    assign sum_mag    = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    assign quo_signed = r_dneg ? DIV_W'(-r_quo) : r_quo;
    assign area_mag   = r_area[AREA_W-1] ? AREA_W'(-r_area) : AREA_W'(r_area);

    assign box_w  = {r_maxx[COORD_W-1], r_maxx} - {r_minx[COORD_W-1], r_minx};
    assign box_h  = {r_maxy[COORD_W-1], r_maxy} - {r_miny[COORD_W-1], r_miny};
    assign box_cx = {r_maxx[COORD_W-1], r_maxx} + {r_minx[COORD_W-1], r_minx};
    assign box_cy = {r_maxy[COORD_W-1], r_maxy} + {r_miny[COORD_W-1], r_miny};

    always_comb begin
        n_state = r_state; n_act = ACT_NONE; n_tsel = r_tsel;
        n_vx = r_vx; n_vy = r_vy; n_last = r_last;
        n_fx = r_fx; n_fy = r_fy; n_sx = r_sx; n_sy = r_sy;
        n_ox = r_ox; n_oy = r_oy; n_nx = r_nx; n_ny = r_ny;
        n_minx = r_minx; n_maxx = r_maxx; n_miny = r_miny; n_maxy = r_maxy;
        n_area = r_area; n_sumx = r_sumx; n_sumy = r_sumy; n_count = r_count;
        n_fsign = r_fsign; n_agree = r_agree; n_turn = r_turn;
        n_few = r_few; n_many = r_many;
        n_dsel = r_dsel; n_dneg = r_dneg; n_quo = r_quo; n_rem = r_rem; n_dcnt = r_dcnt;
        n_cx = r_cx; n_cy = r_cy;
        n_o_valid = take_out ? 1'b0 : r_o_valid;
        n_o_area = r_o_area; n_o_w = r_o_w; n_o_h = r_o_h;
        n_o_cx2 = r_o_cx2; n_o_cy2 = r_o_cy2; n_o_mx = r_o_mx; n_o_my = r_o_my;
        n_o_conv = r_o_conv; n_o_few = r_o_few; n_o_many = r_o_many;
        m_a = '0;
        m_b = '0;

        // The product issued in the previous cycle is folded in here.
        case (r_act)
            ACT_AREA_ADD:  n_area = r_area + {{(AREA_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            ACT_AREA_SUB:  n_area = r_area - {{(AREA_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
            ACT_TURN_LOAD: n_turn = r_prod;
            ACT_TURN_FIRST: n_fsign = turn_neg;
            ACT_TURN_CHECK: begin
                if (turn_neg != r_fsign) begin
                    n_agree = 1'b0;
                end
            end
            default: ;
        endcase

        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_vx = i_vertex_x;
                    n_vy = i_vertex_y;
                    n_last = i_last_vertex;
                    n_state = S_VTX;
                end
            end
            S_VTX: begin
                if (r_count >= MAX_CNT) begin
                    n_count = OVER_CNT;
                    n_state = r_last ? S_CHK : S_IDLE;
                end else begin
                    n_sumx = r_sumx + {{(SUM_W-COORD_W){r_vx[COORD_W-1]}}, r_vx};
                    n_sumy = r_sumy + {{(SUM_W-COORD_W){r_vy[COORD_W-1]}}, r_vy};
                    if (r_count == '0) begin
                        n_fx = r_vx; n_fy = r_vy;
                        n_minx = r_vx; n_maxx = r_vx; n_miny = r_vy; n_maxy = r_vy;
                        n_ox = r_nx; n_oy = r_ny; n_nx = r_vx; n_ny = r_vy;
                        n_count = r_count + CNT_W'(1);
                        n_state = r_last ? S_CHK : S_IDLE;
                    end else begin
                        if (r_vx < r_minx) n_minx = r_vx;
                        if (r_vx > r_maxx) n_maxx = r_vx;
                        if (r_vy < r_miny) n_miny = r_vy;
                        if (r_vy > r_maxy) n_maxy = r_vy;
                        if (r_count == CNT_W'(1)) begin
                            n_sx = r_vx; n_sy = r_vy;
                        end
                        m_a = {r_nx[COORD_W-1], r_nx};
                        m_b = {r_vy[COORD_W-1], r_vy};
                        n_act = ACT_AREA_ADD;
                        n_state = S_E1;
                    end
                end
            end
            S_E1: begin
                m_a = {r_vx[COORD_W-1], r_vx};
                m_b = {r_ny[COORD_W-1], r_ny};
                n_act = ACT_AREA_SUB;
                if (r_count >= CNT_W'(2)) begin
                    n_tsel = TS_VTX;
                    n_state = S_T0;
                end else begin
                    n_ox = r_nx; n_oy = r_ny; n_nx = r_vx; n_ny = r_vy;
                    n_count = r_count + CNT_W'(1);
                    n_state = r_last ? S_CHK : S_IDLE;
                end
            end
            S_T0: begin
                m_a = abx;
                m_b = bcy;
                n_act = ACT_TURN_LOAD;
                n_state = S_T1;
            end
            S_T1: begin
                m_a = aby;
                m_b = bcx;
                unique case (r_tsel)
                    TS_WRAP1: begin
                        n_act = ACT_TURN_CHECK;
                        n_tsel = TS_WRAP2;
                        n_state = S_T0;
                    end
                    TS_WRAP2: begin
                        n_act = ACT_TURN_CHECK;
                        n_state = S_EF0;
                    end
                    default: begin
                        n_act = (r_count == CNT_W'(2)) ? ACT_TURN_FIRST : ACT_TURN_CHECK;
                        n_ox = r_nx; n_oy = r_ny; n_nx = r_vx; n_ny = r_vy;
                        n_count = r_count + CNT_W'(1);
                        n_state = r_last ? S_CHK : S_IDLE;
                    end
                endcase
            end
            S_CHK: begin
                n_many = (r_count > MAX_CNT);
                n_few = (r_count <= MAX_CNT) && (r_count < MIN_CNT);
                if ((r_count > MAX_CNT) || (r_count < MIN_CNT)) begin
                    n_state = S_PUT;
                end else begin
                    n_tsel = TS_WRAP1;
                    n_state = S_T0;
                end
            end
            S_EF0: begin
                m_a = {r_nx[COORD_W-1], r_nx};
                m_b = {r_fy[COORD_W-1], r_fy};
                n_act = ACT_AREA_ADD;
                n_state = S_EF1;
            end
            S_EF1: begin
                m_a = {r_fx[COORD_W-1], r_fx};
                m_b = {r_ny[COORD_W-1], r_ny};
                n_act = ACT_AREA_SUB;
                n_dsel = 1'b0;
                n_state = S_DLOAD;
            end
            S_DLOAD: begin
                n_quo = {sum_mag, FRAC_W'(0)};
                n_dneg = sum_sel[SUM_W-1];
                n_rem = '0;
                n_dcnt = DCNT_W'(DIV_W - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_trial >= {1'b0, r_count}) begin
                    n_rem = CNT_W'(div_trial - {1'b0, r_count});
                    n_quo = {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    n_rem = div_trial[CNT_W-1:0];
                    n_quo = {r_quo[DIV_W-2:0], 1'b0};
                end
                n_dcnt = r_dcnt - DCNT_W'(1);
                if (r_dcnt == '0) begin
                    n_state = S_DSTORE;
                end
            end
            S_DSTORE: begin
                if (r_dsel) begin
                    n_cy = quo_signed[CENT_W-1:0];
                    n_state = S_PUT;
                end else begin
                    n_cx = quo_signed[CENT_W-1:0];
                    n_dsel = 1'b1;
                    n_state = S_DLOAD;
                end
            end
            S_PUT: begin
                if (!r_o_valid || i_result_ready) begin
                    n_o_valid = 1'b1;
                    n_o_few = r_few;
                    n_o_many = r_many;
                    if (r_few || r_many) begin
                        n_o_area = '0; n_o_w = '0; n_o_h = '0;
                        n_o_cx2 = '0; n_o_cy2 = '0; n_o_mx = '0; n_o_my = '0;
                        n_o_conv = 1'b0;
                    end else begin
                        n_o_area = (|area_mag[AREA_W-1:AREA_OUT_W]) ? AREA_SAT
                                                                    : area_mag[AREA_OUT_W-1:0];
                        n_o_w = box_w[SIZE_W-1:0];
                        n_o_h = box_h[SIZE_W-1:0];
                        n_o_cx2 = box_cx;
                        n_o_cy2 = box_cy;
                        n_o_mx = r_cx;
                        n_o_my = r_cy;
                        n_o_conv = r_agree;
                    end
                    n_fx = '0; n_fy = '0; n_sx = '0; n_sy = '0;
                    n_ox = '0; n_oy = '0; n_nx = '0; n_ny = '0;
                    n_minx = '0; n_maxx = '0; n_miny = '0; n_maxy = '0;
                    n_area = '0; n_sumx = '0; n_sumy = '0; n_count = '0;
                    n_fsign = 1'b0; n_agree = 1'b1;
                    n_few = 1'b0; n_many = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_prod = m_a * m_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act <= ACT_NONE;
            r_tsel <= TS_VTX;
            r_o_valid <= 1'b0;
            r_fx <= '0; r_fy <= '0; r_sx <= '0; r_sy <= '0;
            r_ox <= '0; r_oy <= '0; r_nx <= '0; r_ny <= '0;
            r_minx <= '0; r_maxx <= '0; r_miny <= '0; r_maxy <= '0;
            r_area <= '0; r_sumx <= '0; r_sumy <= '0; r_count <= '0;
            r_fsign <= 1'b0; r_agree <= 1'b1;
            r_few <= 1'b0; r_many <= 1'b0; r_dsel <= 1'b0;
        end else begin
            r_state <= n_state;
            r_act <= n_act;
            r_tsel <= n_tsel;
            r_o_valid <= n_o_valid;
            r_fx <= n_fx; r_fy <= n_fy; r_sx <= n_sx; r_sy <= n_sy;
            r_ox <= n_ox; r_oy <= n_oy; r_nx <= n_nx; r_ny <= n_ny;
            r_minx <= n_minx; r_maxx <= n_maxx; r_miny <= n_miny; r_maxy <= n_maxy;
            r_area <= n_area; r_sumx <= n_sumx; r_sumy <= n_sumy; r_count <= n_count;
            r_fsign <= n_fsign; r_agree <= n_agree;
            r_few <= n_few; r_many <= n_many; r_dsel <= n_dsel;
        end
        r_vx <= n_vx; r_vy <= n_vy; r_last <= n_last;
        r_prod <= n_prod; r_turn <= n_turn;
        r_dneg <= n_dneg; r_quo <= n_quo; r_rem <= n_rem; r_dcnt <= n_dcnt;
        r_cx <= n_cx; r_cy <= n_cy;
        r_o_area <= n_o_area; r_o_w <= n_o_w; r_o_h <= n_o_h;
        r_o_cx2 <= n_o_cx2; r_o_cy2 <= n_o_cy2; r_o_mx <= n_o_mx; r_o_my <= n_o_my;
        r_o_conv <= n_o_conv; r_o_few <= n_o_few; r_o_many <= n_o_many;
    end

    assign o_vertex_ready           = (r_state == S_IDLE);
    assign o_result_valid           = r_o_valid;
    assign o_doubled_area           = r_o_area;
    assign o_frame_width            = r_o_w;
    assign o_frame_height           = r_o_h;
    assign o_frame_center_x_doubled = r_o_cx2;
    assign o_frame_center_y_doubled = r_o_cy2;
    assign o_centroid_x_q8          = r_o_mx;
    assign o_centroid_y_q8          = r_o_my;
    assign o_is_convex              = r_o_conv;
    assign o_too_few_points         = r_o_few;
    assign o_too_many_points        = r_o_many;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import cpm_pkg::*;

    localparam int HOLD_CYCLES   = 600;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_BEATS  = 500;
    localparam int SETTLE_CYCLES = 200;
    localparam real TWO_PI       = 6.283185307179586;

    typedef struct {
        longint x;
        longint y;
    } t_pt;

    typedef struct {
        logic        [AREA_OUT_W-1:0] area;
        logic        [SIZE_W-1:0]     width;
        logic        [SIZE_W-1:0]     height;
        logic signed [CTR_W-1:0]      ctr_x2;
        logic signed [CTR_W-1:0]      ctr_y2;
        logic signed [CENT_W-1:0]     mean_x;
        logic signed [CENT_W-1:0]     mean_y;
        logic                         convex;
        logic                         few;
        logic                         many;
    } t_measure;

    logic                        i_clk;
    logic                        i_rst_n          = 1'b0;
    logic                        i_vertex_valid   = 1'b0;
    logic                        o_vertex_ready;
    logic signed [COORD_W-1:0]   i_vertex_x       = '0;
    logic signed [COORD_W-1:0]   i_vertex_y       = '0;
    logic                        i_last_vertex    = 1'b0;
    logic                        o_result_valid;
    logic                        i_result_ready   = 1'b0;
    logic        [AREA_OUT_W-1:0] o_doubled_area;
    logic        [SIZE_W-1:0]    o_frame_width;
    logic        [SIZE_W-1:0]    o_frame_height;
    logic signed [CTR_W-1:0]     o_frame_center_x_doubled;
    logic signed [CTR_W-1:0]     o_frame_center_y_doubled;
    logic signed [CENT_W-1:0]    o_centroid_x_q8;
    logic signed [CENT_W-1:0]    o_centroid_y_q8;
    logic                        o_is_convex;
    logic                        o_too_few_points;
    logic                        o_too_many_points;

    t_pt      vtx_first, vtx_second, vtx_older, vtx_newest;
    longint   shoelace_acc, sum_x, sum_y, min_x, max_x, min_y, max_y;
    int       vtx_count      = 0;
    bit       first_turn_neg = 1'b0;
    bit       turns_same     = 1'b1;
    t_measure pending_measures[$];

    int errors         = 0;
    int beats_sent     = 0;
    int results_seen   = 0;
    int convex_seen    = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    int hold_count     = 0;
    bit steady         = 1'b0;
    bit hold_req       = 1'b0;

    convex_polygon_measure_top dut (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_vertex_valid           (i_vertex_valid),
        .o_vertex_ready           (o_vertex_ready),
        .i_vertex_x               (i_vertex_x),
        .i_vertex_y               (i_vertex_y),
        .i_last_vertex            (i_last_vertex),
        .o_result_valid           (o_result_valid),
        .i_result_ready           (i_result_ready),
        .o_doubled_area           (o_doubled_area),
        .o_frame_width            (o_frame_width),
        .o_frame_height           (o_frame_height),
        .o_frame_center_x_doubled (o_frame_center_x_doubled),
        .o_frame_center_y_doubled (o_frame_center_y_doubled),
        .o_centroid_x_q8          (o_centroid_x_q8),
        .o_centroid_y_q8          (o_centroid_y_q8),
        .o_is_convex              (o_is_convex),
        .o_too_few_points         (o_too_few_points),
        .o_too_many_points        (o_too_many_points)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 96) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic bit turn_is_neg(t_pt a, t_pt b, t_pt c);
        return ((b.x - a.x) * (c.y - b.y) - (b.y - a.y) * (c.x - b.x)) < 0;
    endfunction

    task automatic note_turn(input t_pt a, input t_pt b, input t_pt c, input bit opening);
        bit neg;
        neg = turn_is_neg(a, b, c);
        if (opening) begin
            first_turn_neg = neg;
        end else if (neg != first_turn_neg) begin
            turns_same = 1'b0;
        end
    endtask

    // Accumulates one accepted vertex and, on the marked one, queues the expected measurement.
    task automatic measure_vertex(input logic signed [COORD_W-1:0] vx,
                                  input logic signed [COORD_W-1:0] vy, input logic is_last);
        t_measure m;
        t_pt      cur;
        longint   total, mag;
        cur.x = vx;
        cur.y = vy;
        if (vtx_count < MAX_VERTICES) begin
            if (vtx_count == 0) begin
                vtx_first = cur;
                min_x = cur.x;
                max_x = cur.x;
                min_y = cur.y;
                max_y = cur.y;
            end else begin
                shoelace_acc += vtx_newest.x * cur.y - cur.x * vtx_newest.y;
                if (vtx_count == 1) begin
                    vtx_second = cur;
                end
                if (vtx_count >= 2) begin
                    note_turn(vtx_older, vtx_newest, cur, vtx_count == 2);
                end
                if (cur.x < min_x) min_x = cur.x;
                if (cur.x > max_x) max_x = cur.x;
                if (cur.y < min_y) min_y = cur.y;
                if (cur.y > max_y) max_y = cur.y;
            end
            sum_x += cur.x;
            sum_y += cur.y;
            vtx_older  = vtx_newest;
            vtx_newest = cur;
            vtx_count++;
        end else begin
            vtx_count = MAX_VERTICES + 1;
        end
        if (!is_last) begin
            return;
        end
        m = '{default: '0};
        if (vtx_count > MAX_VERTICES) begin
            m.many = 1'b1;
        end else if (vtx_count < MIN_VERTICES) begin
            m.few = 1'b1;
        end else begin
            note_turn(vtx_older, vtx_newest, vtx_first, 1'b0);
            note_turn(vtx_newest, vtx_first, vtx_second, 1'b0);
            total = shoelace_acc + vtx_newest.x * vtx_first.y - vtx_first.x * vtx_newest.y;
            mag = (total < 0) ? -total : total;
            m.area   = (mag[63:AREA_OUT_W] != 0) ? AREA_SAT : mag[AREA_OUT_W-1:0];
            m.width  = SIZE_W'(max_x - min_x);
            m.height = SIZE_W'(max_y - min_y);
            m.ctr_x2 = CTR_W'(max_x + min_x);
            m.ctr_y2 = CTR_W'(max_y + min_y);
            m.mean_x = CENT_W'((sum_x * 256) / longint'(vtx_count));
            m.mean_y = CENT_W'((sum_y * 256) / longint'(vtx_count));
            m.convex = turns_same;
        end
        pending_measures.push_back(m);
        vtx_first      = '{0, 0};
        vtx_second     = '{0, 0};
        vtx_older      = '{0, 0};
        vtx_newest     = '{0, 0};
        shoelace_acc   = 0;
        sum_x          = 0;
        sum_y          = 0;
        min_x          = 0;
        max_x          = 0;
        min_y          = 0;
        max_y          = 0;
        vtx_count      = 0;
        first_turn_neg = 1'b0;
        turns_same     = 1'b1;
    endtask

    task automatic send_vertex(input logic signed [COORD_W-1:0] vx,
                               input logic signed [COORD_W-1:0] vy, input logic is_last);
        int gap;
        i_vertex_valid <= 1'b1;
        i_vertex_x     <= vx;
        i_vertex_y     <= vy;
        i_last_vertex  <= is_last;
        do @(posedge i_clk); while (!o_vertex_ready);
        measure_vertex(vx, vy, is_last);
        beats_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            i_vertex_valid <= 1'b0;
            i_vertex_x     <= COORD_W'($urandom);
            i_vertex_y     <= COORD_W'($urandom);
            i_last_vertex  <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_vertex_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_measures.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic signed [COORD_W-1:0] clip16(int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return COORD_W'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(bit extreme);
        if (!extreme) begin
            return COORD_W'($urandom);
        end
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return -16'sd1;
            4: return 16'sd1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    task automatic send_scatter_polygon(input int n, input bit extreme);
        int k;
        for (k = 0; k < n; k++) begin
            send_vertex(pick_coord(extreme), pick_coord(extreme), k == n - 1);
        end
    endtask

    // Points on a circle in angular order give a convex outline, either way round.
    task automatic send_circle_polygon();
        int  n, cx, cy, radius, k;
        real phase, arc_step, ang;
        n        = $urandom_range(3, 12);
        cx       = $urandom_range(0, 65535) - 32768;
        cy       = $urandom_range(0, 65535) - 32768;
        radius   = $urandom_range(2, 32767);
        phase    = $urandom_range(0, 359) * TWO_PI / 360.0;
        arc_step = TWO_PI / n;
        if ($urandom_range(0, 1) == 1) begin
            arc_step = -arc_step;
        end
        for (k = 0; k < n; k++) begin
            ang = phase + k * arc_step;
            send_vertex(clip16(cx + $rtoi(radius * $cos(ang))),
                        clip16(cy + $rtoi(radius * $sin(ang))), k == n - 1);
        end
    endtask

    task automatic send_box_polygon();
        logic signed [COORD_W-1:0] bx[4], by[4];
        int                        k;
        bit                        reverse;
        bx[0] = pick_coord(1'b1);
        bx[2] = pick_coord(1'b1);
        by[0] = pick_coord(1'b1);
        by[2] = pick_coord(1'b1);
        bx[1] = bx[2];
        by[1] = by[0];
        bx[3] = bx[0];
        by[3] = by[2];
        reverse = 1'($urandom_range(0, 1));
        for (k = 0; k < 4; k++) begin
            if (reverse) begin
                send_vertex(bx[3-k], by[3-k], k == 3);
            end else begin
                send_vertex(bx[k], by[k], k == 3);
            end
        end
    endtask

    task automatic test_directed_shapes();
        logic signed [COORD_W-1:0] sq_x[4], sq_y[4];
        int                        k;
        // Clockwise triangle spanning the full coordinate range.
        send_vertex(16'sh8000, 16'sh8000, 1'b0);
        send_vertex(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_vertex(16'sh7FFF, 16'sh8000, 1'b1);
        // One and two vertices are too few.
        send_vertex(16'sh7FFF, 16'sh8000, 1'b1);
        send_vertex(-16'sd5, 16'sd7, 1'b0);
        send_vertex(16'sd9, -16'sd3, 1'b1);
        // A concave quadrilateral.
        send_vertex(16'sd0, 16'sd0, 1'b0);
        send_vertex(16'sd10, 16'sd0, 1'b0);
        send_vertex(16'sd2, 16'sd2, 1'b0);
        send_vertex(16'sd0, 16'sd10, 1'b1);
        // Collinear points give zero cross products throughout.
        send_vertex(-16'sd3, -16'sd3, 1'b0);
        send_vertex(16'sd5, 16'sd5, 1'b0);
        send_vertex(16'sd11, 16'sd11, 1'b1);
        // Three laps around the full square push the shoelace sum past the output range.
        sq_x = '{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
        sq_y = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF};
        for (k = 0; k < 12; k++) begin
            send_vertex(sq_x[k%4], sq_y[k%4], k == 11);
        end
        drain_results();
    endtask

    // One polygon runs past the vertex limit, so the count saturates and keeps saturating.
    task automatic test_vertex_limit();
        send_scatter_polygon(MAX_VERTICES + 3, 1'b0);
        drain_results();
    endtask

    // The result side holds off long enough for the block to fill and stall its input.
    task automatic test_result_backpressure();
        hold_req = 1'b1;
        steady   = 1'b1;
        repeat (8) send_scatter_polygon(3, 1'b0);
        steady = 1'b0;
        drain_results();
    endtask

    task automatic test_random_polygons();
        int stop_at;
        stop_at = beats_sent + RANDOM_BEATS;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 24) == 0) begin
                steady = !steady;
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_circle_polygon();
                4, 5:       send_box_polygon();
                6:          send_scatter_polygon($urandom_range(1, 2),
                                                 1'($urandom_range(0, 1)));
                7:          send_scatter_polygon($urandom_range(3, 10), 1'b0);
                default:    send_scatter_polygon($urandom_range(3, 8), 1'b1);
            endcase
        end
        steady = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_shapes();
        test_vertex_limit();
        test_result_backpressure();
        test_random_polygons();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_measures.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_measures.size());
            errors++;
        end
        $display("Sent %0d vertex beats and checked %0d results (%0d convex).",
                 beats_sent, results_seen, convex_seen);
        $display("Covered extremes, degenerate, undersized, oversized and self-crossing polygons.");
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_result_ready <= 1'b0;
            end else if (hold_req) begin
                hold_req = 1'b0;
                i_result_ready <= 1'b0;
                for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
                    @(posedge i_clk);
                end
            end else if (stall_left > 0) begin
                i_result_ready <= 1'b0;
                stall_left--;
            end else begin
                i_result_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_measure want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            results_seen++;
            if (pending_measures.size() == 0) begin
                $display("%0t: result beat arrived with no polygon outstanding", $time);
                errors++;
            end else begin
                want = pending_measures.pop_front();
                if (want.convex) convex_seen++;
                check_field("doubled_area", want.area, o_doubled_area);
                check_field("frame_width", want.width, o_frame_width);
                check_field("frame_height", want.height, o_frame_height);
                check_field("frame_center_x_doubled", want.ctr_x2, o_frame_center_x_doubled);
                check_field("frame_center_y_doubled", want.ctr_y2, o_frame_center_y_doubled);
                check_field("centroid_x_q8", want.mean_x, o_centroid_x_q8);
                check_field("centroid_y_q8", want.mean_y, o_centroid_y_q8);
                check_field("is_convex", want.convex, o_is_convex);
                check_field("too_few_points", want.few, o_too_few_points);
                check_field("too_many_points", want.many, o_too_many_points);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_vertex_valid && o_vertex_ready) || (o_result_valid && i_result_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("%0t: no beat accepted for %0d cycles", $time, idle_cycles);
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

endmodule

// ===== convex_polygon_measure_top.f =====
hdl/cpm_pkg.sv
hdl/convex_polygon_measure_top.sv
tb/tb_top.sv
